/* sv/idle_state_governor_top_defines.svh */
// Assertion macros for the idle-state governor.
// Included by the top level; needs no other file.
`ifndef IDLE_STATE_GOVERNOR_TOP_DEFINES_SVH
`define IDLE_STATE_GOVERNOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define ISG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("idle state governor: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define ISG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("idle state governor: next-cycle check failed");

`endif

/* sv/isg_pkg.sv */
// Shared types, constants and the microcode table of the idle-state governor.
// No dependencies; every file but isg_ram and the defines header imports it.
package isg_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STATE_COUNT = 4'd0,
		REG_TICK_US     = 4'd1
	} cfg_reg_t;

	localparam logic [3:0]  STATE_COUNT_RESET = 4'd1;
	localparam logic [19:0] TICK_US_RESET     = 20'd10000;
	localparam logic [31:0] FUZZ_US           = 32'd4;

	typedef enum logic [1:0] {
		OP_SELECT  = 2'd0,
		OP_REFLECT = 2'd1,
		OP_LOAD    = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] sleep_length_us;
		logic [30:0] latency_limit_us;
		logic [31:0] residency_us;
		logic [2:0]  entry_index;
		logic [31:0] entry_target_us;
		logic [31:0] entry_exit_us;
		logic        entry_time_valid;
	} item_t;

	typedef struct packed {
		logic        tv;
		logic [31:0] exit_us;
		logic [31:0] target_us;
	} entry_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef logic [3:0] pc_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_SEL_INIT,
		ACT_WALK_STEP,
		ACT_SEL_FIN,
		ACT_SEL_ZERO,
		ACT_IDLE,
		ACT_MEAS,
		ACT_CUR,
		ACT_COMMIT,
		ACT_LOAD
	} act_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_START,
		RD_NEXT,
		RD_CHOSEN
	} rd_t;

	typedef enum logic [1:0] {
		C_NEVER,
		C_LIMIT_ZERO,
		C_WALK_GO
	} cond_t;

	typedef struct packed {
		act_t  act;
		rd_t   rd;
		cond_t cond;
		pc_t   target;
		logic  done;
	} uword_t;

	typedef struct packed {
		logic   fire;
		uword_t w;
	} seq_ctrl_t;

	typedef struct packed {
		logic limit_zero;
		logic walk_go;
		logic out_free;
	} seq_stat_t;

	localparam pc_t PC_SEL      = 4'd0;
	localparam pc_t PC_SEL_INIT = 4'd1;
	localparam pc_t PC_WALK     = 4'd2;
	localparam pc_t PC_FIN      = 4'd3;
	localparam pc_t PC_ZERO     = 4'd4;
	localparam pc_t PC_REF_RD   = 4'd5;
	localparam pc_t PC_REF_IDLE = 4'd6;
	localparam pc_t PC_REF_MEAS = 4'd7;
	localparam pc_t PC_REF_CUR  = 4'd8;
	localparam pc_t PC_REF_CMT  = 4'd9;
	localparam pc_t PC_LOAD     = 4'd10;
	localparam pc_t PC_NOP      = 4'd11;

	// Control store: one word per step.
	function automatic uword_t ucode(pc_t pc);
		uword_t w;
		w = '{act: ACT_NONE, rd: RD_NONE, cond: C_NEVER, target: PC_SEL, done: 1'b0};
		case (pc)
			PC_SEL: begin
				w.cond   = C_LIMIT_ZERO;
				w.target = PC_ZERO;
			end
			PC_SEL_INIT: begin
				w.act = ACT_SEL_INIT;
				w.rd  = RD_START;
			end
			PC_WALK: begin
				w.act    = ACT_WALK_STEP;
				w.rd     = RD_NEXT;
				w.cond   = C_WALK_GO;
				w.target = PC_WALK;
			end
			PC_FIN: begin
				w.act  = ACT_SEL_FIN;
				w.done = 1'b1;
			end
			PC_ZERO: begin
				w.act  = ACT_SEL_ZERO;
				w.done = 1'b1;
			end
			PC_REF_RD:   w.rd  = RD_CHOSEN;
			PC_REF_IDLE: w.act = ACT_IDLE;
			PC_REF_MEAS: w.act = ACT_MEAS;
			PC_REF_CUR:  w.act = ACT_CUR;
			PC_REF_CMT: begin
				w.act  = ACT_COMMIT;
				w.done = 1'b1;
			end
			PC_LOAD: begin
				w.act  = ACT_LOAD;
				w.done = 1'b1;
			end
			default: w.done = 1'b1;
		endcase
		return w;
	endfunction

	function automatic pc_t entry_pc(logic [1:0] op);
		pc_t pc;
		case (op)
			OP_SELECT:  pc = PC_SEL;
			OP_REFLECT: pc = PC_REF_RD;
			OP_LOAD:    pc = PC_LOAD;
			default:    pc = PC_NOP;
		endcase
		return pc;
	endfunction

endpackage

/* sv/isg_if.sv */
// Channel interfaces of the idle-state governor: request, result, config write.
// Depends on isg_pkg for the config port widths.
interface isg_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] sleep_length_us;
	logic [30:0] latency_limit_us;
	logic [31:0] residency_us;
	logic [2:0]  entry_index;
	logic [31:0] entry_target_us;
	logic [31:0] entry_exit_us;
	logic        entry_time_valid;

	modport source (output valid, operation, sleep_length_us, latency_limit_us,
		residency_us, entry_index, entry_target_us, entry_exit_us, entry_time_valid,
		input ready);
	modport sink (input valid, operation, sleep_length_us, latency_limit_us,
		residency_us, entry_index, entry_target_us, entry_exit_us, entry_time_valid,
		output ready);
endinterface

interface isg_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  chosen_state;
	logic [31:0] prediction_us;

	modport source (output valid, chosen_state, prediction_us, input ready);
	modport sink (input valid, chosen_state, prediction_us, output ready);
endinterface

interface isg_cfg_if import isg_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/isg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module isg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/isg_seq.sv */
// Microcode sequencer: step counter, control store fetch and conditional jumps.
// Depends on isg_pkg for the control word and the program.
module isg_seq import isg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  seq_stat_t  stat,
	output seq_ctrl_t  ctrl
);

	logic   busy_q;
	pc_t    pc_q;
	uword_t w;
	logic   jump;

	assign w        = ucode(pc_q);
	assign in_ready = !busy_q;

	always_comb begin
		case (w.cond)
			C_LIMIT_ZERO: jump = stat.limit_zero;
			C_WALK_GO:    jump = stat.walk_go;
			default:      jump = 1'b0;
		endcase
	end

	// a final step waits for the output register to free up
	assign ctrl.fire = busy_q && (!w.done || stat.out_free);
	assign ctrl.w    = w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= PC_SEL;
		end else if (in_valid && !busy_q) begin
			busy_q <= 1'b1;
			pc_q   <= entry_pc(operation);
		end else if (ctrl.fire) begin
			if (w.done) begin
				busy_q <= 1'b0;
			end else if (jump) begin
				pc_q <= w.target;
			end else begin
				pc_q <= pc_q + 4'd1;
			end
		end
	end

endmodule

/* sv/isg_dp.sv */
// Datapath of the governor: state registers, table RAM and result register, all driven
// by the control word, plus config registers set by config writes. Uses isg_pkg, isg_ram.
module isg_dp import isg_pkg::*; #(
	parameter int MAX_STATES  = 8,
	parameter int START_INDEX = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_accept,
	input  item_t       item_d,
	input  cfg_wr_t     cfg_wr,
	input  seq_ctrl_t   ctrl,
	output seq_stat_t   stat,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  res_chosen,
	output logic [31:0] res_pred
);

	localparam int AW = $clog2(MAX_STATES);
	localparam int CW = $clog2(MAX_STATES + 1);

	item_t item_q;

	logic [3:0]  state_count_q;
	logic [19:0] tick_q;

	logic [AW-1:0] chosen_q,   chosen_d;
	logic [31:0]   expected_q, expected_d;
	logic [31:0]   smooth_q,   smooth_d;
	logic [31:0]   cur_q,      cur_d;
	logic [31:0]   lastm_q,    lastm_d;
	logic [31:0]   elapsed_q,  elapsed_d;

	logic [CW-1:0] idx_q,  idx_d;
	logic [31:0]   idle_q, idle_d;
	logic [31:0]   rhs_q,  rhs_d;
	logic [31:0]   meas_q, meas_d;

	logic          out_valid_q;
	logic [2:0]    out_chosen_q;
	logic [31:0]   out_pred_q;

	logic [CW-1:0] count;
	logic [32:0]   smooth_sum;
	logic [32:0]   meas_sum;
	logic [31:0]   fuzz_idle;
	logic          fuzz_lt;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wdata, rd;

	assign count = (32'(state_count_q) > MAX_STATES) ? CW'(MAX_STATES) : CW'(state_count_q);

	assign smooth_sum = {1'b0, smooth_q} + {1'b0, cur_q};
	assign meas_sum   = {1'b0, elapsed_q} + {1'b0, idle_q};
	assign fuzz_idle  = idle_q + FUZZ_US;
	assign fuzz_lt    = fuzz_idle < rhs_q;

	assign stat.limit_zero = (item_q.latency_limit_us == '0);
	assign stat.walk_go    = (idx_q < count) && !(rd.target_us > expected_q)
		&& !(rd.target_us > smooth_q) && !(rd.exit_us > {1'b0, item_q.latency_limit_us});
	assign stat.out_free   = !out_valid_q || res_ready;

	// table RAM: load writes, walk and reflect read
	assign ram_we    = ctrl.fire && (ctrl.w.act == ACT_LOAD)
		&& (32'(item_q.entry_index) < MAX_STATES);
	assign ram_waddr = AW'(item_q.entry_index);
	assign ram_wdata = '{tv: item_q.entry_time_valid, exit_us: item_q.entry_exit_us,
		target_us: item_q.entry_target_us};
	assign ram_re    = ctrl.fire && (ctrl.w.rd != RD_NONE);

	always_comb begin
		case (ctrl.w.rd)
			RD_START:  ram_raddr = AW'(START_INDEX + 1);
			RD_NEXT:   ram_raddr = AW'(idx_q + CW'(1));
			RD_CHOSEN: ram_raddr = chosen_q;
			default:   ram_raddr = '0;
		endcase
	end

	isg_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_STATES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd)
	);

	always_comb begin
		chosen_d   = chosen_q;
		expected_d = expected_q;
		smooth_d   = smooth_q;
		cur_d      = cur_q;
		lastm_d    = lastm_q;
		elapsed_d  = elapsed_q;
		idx_d      = idx_q;
		idle_d     = idle_q;
		rhs_d      = rhs_q;
		meas_d     = meas_q;
		if (ctrl.fire) begin
			case (ctrl.w.act)
				ACT_SEL_INIT: begin
					expected_d = item_q.sleep_length_us;
					smooth_d   = smooth_sum[32:1];
					idx_d      = CW'(START_INDEX + 1);
				end
				ACT_WALK_STEP: begin
					if (stat.walk_go) begin
						idx_d = idx_q + CW'(1);
					end
				end
				ACT_SEL_FIN:  chosen_d = AW'(idx_q - CW'(1));
				ACT_SEL_ZERO: chosen_d = '0;
				ACT_IDLE: begin
					// fall back to the tick when the state cannot time itself
					idle_d = rd.tv ? item_q.residency_us : {12'd0, tick_q};
					rhs_d  = expected_q - rd.exit_us;
				end
				ACT_MEAS: meas_d = meas_sum[32] ? '1 : meas_sum[31:0];
				ACT_CUR:  cur_d  = (meas_q > lastm_q) ? meas_q : lastm_q;
				ACT_COMMIT: begin
					if (fuzz_lt) begin
						lastm_d   = meas_q;
						elapsed_d = '0;
					end else begin
						elapsed_d = meas_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chosen_q      <= '0;
			expected_q    <= '0;
			smooth_q      <= '0;
			cur_q         <= '0;
			lastm_q       <= '0;
			elapsed_q     <= '0;
			state_count_q <= STATE_COUNT_RESET;
			tick_q        <= TICK_US_RESET;
			out_valid_q   <= 1'b0;
		end else begin
			chosen_q   <= chosen_d;
			expected_q <= expected_d;
			smooth_q   <= smooth_d;
			cur_q      <= cur_d;
			lastm_q    <= lastm_d;
			elapsed_q  <= elapsed_d;
			if (cfg_wr.we) begin
				case (cfg_wr.idx)
					REG_STATE_COUNT: state_count_q <= cfg_wr.data[3:0];
					REG_TICK_US:     tick_q        <= cfg_wr.data;
					default: ;
				endcase
			end
			if (ctrl.fire && ctrl.w.done) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			item_q <= item_d;
		end
		idx_q  <= idx_d;
		idle_q <= idle_d;
		rhs_q  <= rhs_d;
		meas_q <= meas_d;
		if (ctrl.fire && ctrl.w.done) begin
			out_chosen_q <= 3'(chosen_d);
			out_pred_q   <= smooth_d;
		end
	end

	assign res_valid  = out_valid_q;
	assign res_chosen = out_chosen_q;
	assign res_pred   = out_pred_q;

endmodule

/* sv/idle_state_governor_top.sv */
// Idle-state governor. One request at a time runs through a microcoded
// sequencer; every request yields exactly one result (chosen state and the
// smoothed prediction). A select with a zero latency limit skips the walk;
// otherwise the walk passes at most MAX_STATES - START_INDEX - 1 table
// entries, reading one per cycle through the single read port of the state
// table RAM. A finished result sits in an output register, so the next
// request is taken while it waits; the request after that stalls in its
// final step until the result is taken. The table has no clearing pass: the
// user must see that select and reflect read only loaded entries; the block
// itself does not enforce it.
// Uses isg_pkg, the channel interfaces, isg_seq and isg_dp.
`include "idle_state_governor_top_defines.svh"

module idle_state_governor_top import isg_pkg::*; #(
	parameter int MAX_STATES  = 8,
	parameter int START_INDEX = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	isg_item_if.sink     item,
	isg_result_if.source result,
	isg_cfg_if.sink      cfg
);

	item_t     item_d;
	cfg_wr_t   cfg_wr;
	seq_ctrl_t ctrl;
	seq_stat_t stat;
	logic      item_accept;

	assign item_d = '{
		operation:        item.operation,
		sleep_length_us:  item.sleep_length_us,
		latency_limit_us: item.latency_limit_us,
		residency_us:     item.residency_us,
		entry_index:      item.entry_index,
		entry_target_us:  item.entry_target_us,
		entry_exit_us:    item.entry_exit_us,
		entry_time_valid: item.entry_time_valid
	};

	assign item_accept = item.valid && item.ready;

	// config writes are always accepted
	assign cfg.ready = 1'b1;
	assign cfg_wr    = '{we: cfg.valid, idx: cfg.index, data: cfg.data};

	isg_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.operation (item.operation),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	isg_dp #(
		.MAX_STATES  (MAX_STATES),
		.START_INDEX (START_INDEX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_accept (item_accept),
		.item_d      (item_d),
		.cfg_wr      (cfg_wr),
		.ctrl        (ctrl),
		.stat        (stat),
		.res_valid   (result.valid),
		.res_ready   (result.ready),
		.res_chosen  (result.chosen_state),
		.res_pred    (result.prediction_us)
	);

	`ISG_ASSERT_NXT(a_one_request_at_a_time, clk, arst_n, item_accept, !item.ready)
	`ISG_ASSERT_IMP(a_no_step_while_idle, clk, arst_n, item.ready, !ctrl.fire)
	`ISG_ASSERT_NXT(a_final_step_posts_result, clk, arst_n, ctrl.fire && ctrl.w.done,
		result.valid)

endmodule

/* test/isg_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the idle-state governor: watches request, result and config channels.
// Tracks its own copy of the governor state, predicts each result and compares in order.
// Depends on isg_pkg and the channel interfaces in isg_if.sv.
module isg_checker import isg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	isg_item_if   item,
	isg_result_if result,
	isg_cfg_if    cfg,
	output int    fail_count,
	output int    in_flight
);

	localparam int TABLE_DEPTH = 8;
	localparam int FIRST_STATE = 0;

	typedef struct packed {
		logic [2:0]  chosen_state;
		logic [31:0] prediction_us;
	} outcome_t;

	logic [3:0]  states_used;
	logic [19:0] tick_us;
	logic [2:0]  chosen;
	logic [31:0] wake_us;
	logic [31:0] smoothed_us;
	logic [31:0] current_us;
	logic [31:0] last_meas_us;
	logic [31:0] accum_us;
	logic [31:0] target_tab [TABLE_DEPTH];
	logic [31:0] exit_tab   [TABLE_DEPTH];
	logic        tv_tab     [TABLE_DEPTH];
	outcome_t    outcome_q  [$];
	outcome_t    want;
	outcome_t    produced;

	initial fail_count = 0;

	task automatic flag(input string msg);
		$display("checker: mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic pick_state(input logic [31:0] sleep_len, input logic [30:0] limit);
		int          depth;
		int          i;
		logic [32:0] pair_sum;
		depth = (states_used > TABLE_DEPTH) ? TABLE_DEPTH : int'(states_used);
		if (limit == '0) begin
			chosen = '0;
		end else begin
			wake_us     = sleep_len;
			pair_sum    = {1'b0, smoothed_us} + {1'b0, current_us};
			smoothed_us = pair_sum[32:1];
			i = FIRST_STATE + 1;
			// advance while the next state still fits every bound
			while (i < depth && target_tab[i] <= wake_us && target_tab[i] <= smoothed_us
					&& exit_tab[i] <= {1'b0, limit})
				i++;
			chosen = 3'(i - 1);
		end
	endtask

	task automatic account_wakeup(input logic [31:0] residency);
		logic [31:0] idle;
		logic [31:0] measured;
		logic [31:0] lhs;
		logic [31:0] rhs;
		logic [32:0] total;
		idle     = tv_tab[chosen] ? residency : {12'd0, tick_us};
		total    = {1'b0, accum_us} + {1'b0, idle};
		measured = total[32] ? 32'hFFFF_FFFF : total[31:0];
		lhs      = idle + FUZZ_US;
		rhs      = wake_us - exit_tab[chosen];
		current_us = (measured > last_meas_us) ? measured : last_meas_us;
		if (lhs < rhs) begin
			last_meas_us = measured;
			accum_us     = '0;
		end else begin
			accum_us = measured;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			states_used  = STATE_COUNT_RESET;
			tick_us      = TICK_US_RESET;
			chosen       = '0;
			wake_us      = '0;
			smoothed_us  = '0;
			current_us   = '0;
			last_meas_us = '0;
			accum_us     = '0;
			outcome_q.delete();
			in_flight <= 0;
		end else begin
			// retire first: a result always belongs to an earlier request
			if (result.valid && result.ready) begin
				if (outcome_q.size() == 0) begin
					flag($sformatf("result with nothing pending: state %0d prediction %0d",
						result.chosen_state, result.prediction_us));
				end else begin
					want = outcome_q.pop_front();
					if (result.chosen_state !== want.chosen_state)
						flag($sformatf("chosen_state %0d, predicted %0d",
							result.chosen_state, want.chosen_state));
					if (result.prediction_us !== want.prediction_us)
						flag($sformatf("prediction_us %0d, predicted %0d",
							result.prediction_us, want.prediction_us));
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_STATE_COUNT: states_used = cfg.data[3:0];
					REG_TICK_US:     tick_us = cfg.data;
					default: ;
				endcase
			end
			if (item.valid && item.ready) begin
				case (item.operation)
					OP_SELECT:  pick_state(item.sleep_length_us, item.latency_limit_us);
					OP_REFLECT: account_wakeup(item.residency_us);
					OP_LOAD: begin
						target_tab[item.entry_index] = item.entry_target_us;
						exit_tab[item.entry_index]   = item.entry_exit_us;
						tv_tab[item.entry_index]     = item.entry_time_valid;
					end
					default: ;
				endcase
				produced.chosen_state  = chosen;
				produced.prediction_us = smoothed_us;
				outcome_q.push_back(produced);
			end
			in_flight <= outcome_q.size();
		end
	end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Top of the idle-state governor testbench: clock, reset, request and config stimulus, verdict.
// Depends on isg_pkg, isg_if.sv, the governor RTL and isg_checker.
module testbench;
	import isg_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASES       = 9;
	localparam int ITEMS_PHASE  = 118;
	localparam int TAIL_CYCLES  = 30;

	logic clk;
	logic arst_n;
	int   cycles = 0;
	int   tx_idle_pct;
	int   rx_idle_pct;
	int   fail_count;
	int   in_flight;

	isg_item_if   item_bus ();
	isg_result_if result_bus ();
	isg_cfg_if    cfg_bus ();

	idle_state_governor_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	isg_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_bus),
		.result     (result_bus),
		.cfg        (cfg_bus),
		.fail_count (fail_count),
		.in_flight  (in_flight)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	always @(posedge clk) result_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);

	function automatic logic [31:0] rand_us();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return $urandom_range(0, 4000);
		else if (pick < 75)
			return $urandom_range(0, 300000);
		else if (pick < 90)
			return $urandom;
		else if (pick < 95)
			return 32'hFFFF_FFFF - $urandom_range(0, 8);
		else
			return $urandom_range(0, 4);
	endfunction

	function automatic logic [30:0] rand_limit();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return '0;
		else if (pick < 15)
			return 31'h7FFF_FFFF;
		else
			return 31'(rand_us());
	endfunction

	// unused fields carry random values; the block must ignore them
	function automatic item_t noise_item();
		item_t r;
		r.operation        = 2'($urandom);
		r.sleep_length_us  = $urandom;
		r.latency_limit_us = 31'($urandom);
		r.residency_us     = $urandom;
		r.entry_index      = 3'($urandom);
		r.entry_target_us  = $urandom;
		r.entry_exit_us    = $urandom;
		r.entry_time_valid = 1'($urandom);
		return r;
	endfunction

	function automatic item_t select_item(input logic [31:0] sleep_len, input logic [30:0] limit);
		item_t r;
		r = noise_item();
		r.operation        = OP_SELECT;
		r.sleep_length_us  = sleep_len;
		r.latency_limit_us = limit;
		return r;
	endfunction

	function automatic item_t reflect_item(input logic [31:0] residency);
		item_t r;
		r = noise_item();
		r.operation    = OP_REFLECT;
		r.residency_us = residency;
		return r;
	endfunction

	function automatic item_t load_item(input logic [2:0] idx, input logic [31:0] tgt,
			input logic [31:0] ext, input logic tv);
		item_t r;
		r = noise_item();
		r.operation        = OP_LOAD;
		r.entry_index      = idx;
		r.entry_target_us  = tgt;
		r.entry_exit_us    = ext;
		r.entry_time_valid = tv;
		return r;
	endfunction

	task automatic drive_request(input item_t r);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid            <= 1'b1;
		item_bus.operation        <= r.operation;
		item_bus.sleep_length_us  <= r.sleep_length_us;
		item_bus.latency_limit_us <= r.latency_limit_us;
		item_bus.residency_us     <= r.residency_us;
		item_bus.entry_index      <= r.entry_index;
		item_bus.entry_target_us  <= r.entry_target_us;
		item_bus.entry_exit_us    <= r.entry_exit_us;
		item_bus.entry_time_valid <= r.entry_time_valid;
		@(posedge clk);
		while (!item_bus.ready)
			@(posedge clk);
	endtask

	// drop valid and hold until every predicted result has come back
	task automatic drain();
		item_bus.valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [19:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	// ordered tables climb in target and exit latency so walks run deep
	task automatic load_table(input bit ordered);
		logic [31:0] tgt;
		logic [31:0] ext;
		tgt = $urandom_range(0, 50);
		ext = $urandom_range(0, 5);
		for (int e = 0; e < 8; e++) begin
			if (ordered)
				drive_request(load_item(3'(e), tgt, ext, $urandom_range(0, 9) != 0));
			else
				drive_request(load_item(3'(e), rand_us(), rand_us(), 1'($urandom)));
			tgt += $urandom_range(1, 900);
			ext += $urandom_range(0, 300);
		end
	endtask

	task automatic run_random(input int n);
		int    sent;
		item_t r;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < 80) begin
				drive_request(select_item(rand_us(), rand_limit()));
				drive_request(reflect_item(rand_us()));
				sent += 2;
			end else begin
				r = noise_item();
				if (r.operation != OP_LOAD && $urandom_range(0, 1) == 0)
					r.residency_us = rand_us();
				drive_request(r);
				if (r.operation != 2'd3)
					sent++;
			end
		end
	endtask

	initial begin
		logic [3:0]  count_set;
		logic [19:0] tick_set;

		arst_n                    <= 1'b0;
		item_bus.valid            <= 1'b0;
		item_bus.operation        <= '0;
		item_bus.sleep_length_us  <= '0;
		item_bus.latency_limit_us <= '0;
		item_bus.residency_us     <= '0;
		item_bus.entry_index      <= '0;
		item_bus.entry_target_us  <= '0;
		item_bus.entry_exit_us    <= '0;
		item_bus.entry_time_valid <= 1'b0;
		cfg_bus.valid             <= 1'b0;
		cfg_bus.index             <= '0;
		cfg_bus.data              <= '0;
		tx_idle_pct               <= 11;
		rx_idle_pct               <= 79;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: a single state, so every walk is empty
		drive_request(load_item(3'd0, 32'd0, 32'd0, 1'b1));
		drive_request(load_item(3'd1, 32'd100, 32'd10, 1'b1));
		drive_request(load_item(3'd2, 32'd200, 32'd20, 1'b0));
		drive_request(load_item(3'd3, 32'd300, 32'd30, 1'b1));
		drive_request(load_item(3'd4, 32'd400, 32'd40, 1'b1));
		drive_request(load_item(3'd5, 32'd500, 32'd50, 1'b0));
		drive_request(load_item(3'd6, 32'd600, 32'd60, 1'b1));
		drive_request(load_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
		drive_request(select_item(32'hFFFF_FFFF, 31'h7FFF_FFFF));
		drive_request(reflect_item(32'hFFFF_FFFF));
		drive_request(reflect_item(32'd0));
		begin
			item_t r;
			r = noise_item();
			r.operation = 2'd3;
			drive_request(r);
		end
		drive_request(select_item(32'd5, 31'd0));
		drain();

		// full table with a zero tick
		write_register(REG_STATE_COUNT, 20'd8);
		write_register(REG_TICK_US, 20'd0);
		drive_request(select_item(32'hFFFF_FFFF, 31'h7FFF_FFFF));
		drive_request(select_item(32'hFFFF_FFFF, 31'h7FFF_FFFF));
		drive_request(reflect_item(32'd1234));
		drive_request(select_item(32'd250, 31'd1000));
		drive_request(reflect_item(32'd777));
		drive_request(select_item(32'd0, 31'd1));
		drive_request(reflect_item(32'hFFFF_FFF0));
		drive_request(reflect_item(32'd100));
		drive_request(select_item(32'd1000, 31'd35));
		drive_request(load_item(3'd3, 32'd300, 32'd30, 1'b0));
		drive_request(reflect_item(32'd55));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			if (p == 3) begin
				tx_idle_pct <= 79;
				rx_idle_pct <= 11;
			end
			if (p == 6) begin
				tx_idle_pct <= 0;
				rx_idle_pct <= 0;
			end
			case (p)
				0: begin count_set = 4'd8;  tick_set = 20'd1000000; end
				1: begin count_set = 4'd15; tick_set = 20'hFFFFF;   end
				2: begin count_set = 4'd0;  tick_set = 20'd1;       end
				3: begin count_set = 4'd3;  tick_set = 20'($urandom); end
				4: begin count_set = 4'd1;  tick_set = 20'd10000;   end
				5: begin count_set = 4'd5;  tick_set = 20'd0;       end
				6: begin count_set = 4'd12; tick_set = 20'($urandom_range(1, 5000)); end
				7: begin count_set = 4'd2;  tick_set = 20'($urandom); end
				default: begin count_set = 4'd8; tick_set = 20'd1; end
			endcase
			// upper data bits are don't-care for the state count register
			write_register(REG_STATE_COUNT, {16'($urandom), count_set});
			write_register(REG_TICK_US, tick_set);
			load_table(p % 3 != 2);
			run_random(ITEMS_PHASE);
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/isg_pkg.sv
sv/isg_if.sv
sv/isg_ram.sv
sv/isg_seq.sv
sv/isg_dp.sv
sv/idle_state_governor_top.sv
test/isg_checker.sv
test/testbench.sv
